FILE: design/epsm_pkg.sv
// Shared types and constants for the encoder period speed meter.
package epsm_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned QUIET_W   = 16;
	localparam int unsigned CLK_HZ_W  = 27;
	localparam int unsigned PPR_W     = 12;
	localparam int unsigned TICK_W    = 10;
	localparam int unsigned TMO_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 27;
	localparam int unsigned SCALE_W   = 10;
	localparam int unsigned NUM_W     = CLK_HZ_W + SCALE_W;
	localparam int unsigned DEN_W     = PPR_W + TIME_W;
	localparam int unsigned DVS_W     = DEN_W + SPEED_W;

	// tenths of rpm: 60 s/min times 10
	localparam logic [SCALE_W-1:0] RPM_SCALE = 10'd600;

	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd3;

	localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RST   = 27'd16000000;
	localparam logic [PPR_W-1:0]    PULSES_REV_RST = 12'd95;
	localparam logic [TICK_W-1:0]   TICK_MS_RST    = 10'd10;
	localparam logic [TMO_W-1:0]    TIMEOUT_MS_RST = 16'd200;

	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic                done;
		logic                sat;
		logic [SPEED_W-1:0]  quot;
	} epsm_div_res_t;

endpackage

FILE: design/epsm_if.sv
// Item channel interfaces: encoder events in, meter results out.
interface epsm_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] capture_time;
	logic        direction_high;

	modport source (output valid, operation, capture_time, direction_high, input ready);
	modport sink   (input valid, operation, capture_time, direction_high, output ready);
endinterface

interface epsm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_count;
	logic               moving_forward;
	logic [31:0]        period_ticks;
	logic [15:0]        rpm_tenths;

	modport source (output valid, position_count, moving_forward, period_ticks, rpm_tenths,
		input ready);
	modport sink   (input valid, position_count, moving_forward, period_ticks, rpm_tenths,
		output ready);
endinterface

FILE: design/epsm_div.sv
// Iterative restoring divider with 16-bit saturating quotient.
module epsm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [epsm_pkg::NUM_W-1:0]    num,
	input  logic [epsm_pkg::DEN_W-1:0]    den,
	output epsm_pkg::epsm_div_res_t       res
);
	import epsm_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE,
		D_SAT,
		D_ITER
	} div_state_t;

	div_state_t           state_q;
	logic [NUM_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [SPEED_W-1:0]   quot_q;
	logic [3:0]           cnt_q;
	logic                 done_q;
	logic                 sat_q;
	logic                 ge;

	assign ge  = {{(DVS_W-NUM_W){1'b0}}, rem_q} >= dvs_q;
	assign res = '{done: done_q, sat: sat_q, quot: quot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
			dvs_q   <= '0;
			quot_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						rem_q   <= num;
						dvs_q   <= {den, {SPEED_W{1'b0}}};
						quot_q  <= '0;
						cnt_q   <= '0;
						sat_q   <= 1'b0;
						state_q <= D_SAT;
					end
				end
				D_SAT: begin
					// quotient would not fit in 16 bits
					if (ge) begin
						sat_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						dvs_q   <= dvs_q >> 1;
						state_q <= D_ITER;
					end
				end
				D_ITER: begin
					if (ge) begin
						rem_q <= rem_q - dvs_q[NUM_W-1:0];
					end
					quot_q <= {quot_q[SPEED_W-2:0], ge};
					dvs_q  <= dvs_q >> 1;
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/encoder_period_speed_meter_core.sv
// Encoder period speed meter: one channel, position, period and rpm from pulse captures.
// Each input item is either an encoder pulse (operation 0) carrying its capture timestamp
// and direction pin level, or a periodic tick (operation 1). Every item yields exactly one
// result showing position, direction, last period and speed after the update. A pulse
// takes the period as the 32-bit wrapping timestamp difference, steps the signed position,
// clears the quiet timer and recomputes rpm_tenths = clock_hz*600 / (pulses_per_rev*period),
// truncated and saturated at 65535; a zero divisor keeps the previous speed. A tick adds
// tick_ms to the saturating quiet timer and forces speed to zero once the timer exceeds
// timeout_ms. A pulse item passes through the accept, the multiply step that forms both
// products, the divider start, a saturation check and sixteen quotient steps in the
// restoring divider, the take of the quotient and the load of the result register. A
// saturating quotient ends the divider after the check, a zero divisor skips the divider,
// and a tick goes straight from the accept to the load. The input is not ready while an
// item is in work; the result register lets the next item enter while a result waits,
// and the load of a new result holds until the waiting one is taken. Configuration writes
// are taken at any cycle with cfg_we high and must only be issued while the block is idle.
module encoder_period_speed_meter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [epsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [epsm_pkg::CFG_W-1:0]         cfg_data,
	epsm_in_if.sink                            item_in,
	epsm_out_if.source                         result_out
);
	import epsm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                 state_q;

	// configuration
	logic [CLK_HZ_W-1:0]    clock_hz_q;
	logic [PPR_W-1:0]       ppr_q;
	logic [TICK_W-1:0]      tick_ms_q;
	logic [TMO_W-1:0]       timeout_q;

	// channel state
	logic [TIME_W-1:0]      prev_time_q;
	logic [TIME_W-1:0]      period_q;
	logic [POS_W-1:0]       pos_q;
	logic                   fwd_q;
	logic [SPEED_W-1:0]     speed_q;
	logic [QUIET_W-1:0]     quiet_q;

	// divider operands
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       den_q;
	logic                   div_start;
	epsm_div_res_t          div_res;

	// result register
	logic                   out_valid_q;
	logic [POS_W-1:0]       out_pos_q;
	logic                   out_fwd_q;
	logic [TIME_W-1:0]      out_period_q;
	logic [SPEED_W-1:0]     out_speed_q;

	logic                   in_acc;
	logic [QUIET_W:0]       quiet_sum;
	logic [QUIET_W-1:0]     quiet_next;
	logic [CLK_HZ_W+SCALE_W-1:0] num_prod;
	logic [DEN_W-1:0]       den_prod;

	assign item_in.ready = (state_q == ST_IDLE);
	assign in_acc        = item_in.valid && item_in.ready;

	assign quiet_sum  = {1'b0, quiet_q} + {{(QUIET_W+1-TICK_W){1'b0}}, tick_ms_q};
	assign quiet_next = quiet_sum[QUIET_W] ? {QUIET_W{1'b1}} : quiet_sum[QUIET_W-1:0];

	assign num_prod = clock_hz_q * RPM_SCALE;
	assign den_prod = ppr_q * period_q;

	assign div_start = (state_q == ST_START) && (den_q != '0);

	assign result_out.valid          = out_valid_q;
	assign result_out.position_count = out_pos_q;
	assign result_out.moving_forward = out_fwd_q;
	assign result_out.period_ticks   = out_period_q;
	assign result_out.rpm_tenths     = out_speed_q;

	epsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.res    (div_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RST;
			ppr_q      <= PULSES_REV_RST;
			tick_ms_q  <= TICK_MS_RST;
			timeout_q  <= TIMEOUT_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOCK_HZ:   clock_hz_q <= cfg_data[CLK_HZ_W-1:0];
				REG_PULSES_REV: ppr_q      <= cfg_data[PPR_W-1:0];
				REG_TICK_MS:    tick_ms_q  <= cfg_data[TICK_W-1:0];
				REG_TIMEOUT_MS: timeout_q  <= cfg_data[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, channel state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_time_q  <= '0;
			period_q     <= '0;
			pos_q        <= '0;
			fwd_q        <= 1'b1;
			speed_q      <= '0;
			quiet_q      <= '0;
			num_q        <= '0;
			den_q        <= '0;
			out_valid_q  <= 1'b0;
			out_pos_q    <= '0;
			out_fwd_q    <= 1'b0;
			out_period_q <= '0;
			out_speed_q  <= '0;
		end else begin
			// drop the result once the sink takes it, unless a new one loads now
			if (out_valid_q && result_out.ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (item_in.operation == OP_PULSE) begin
							period_q    <= item_in.capture_time - prev_time_q;
							prev_time_q <= item_in.capture_time;
							fwd_q       <= item_in.direction_high;
							pos_q       <= item_in.direction_high ? pos_q + 32'd1
								: pos_q - 32'd1;
							quiet_q     <= '0;
							state_q     <= ST_MUL;
						end else begin
							quiet_q <= quiet_next;
							if (quiet_next > timeout_q) begin
								speed_q <= '0;
							end
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					// both products formed in the same cycle, registered before the divider
					num_q   <= num_prod[NUM_W-1:0];
					den_q   <= den_prod;
					state_q <= ST_START;
				end
				ST_START: begin
					// zero period or zero pulses_per_rev: keep the old speed
					state_q <= (den_q != '0) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_res.done) begin
						speed_q <= div_res.sat ? {SPEED_W{1'b1}} : div_res.quot;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold while an earlier result still waits
					if (!out_valid_q || result_out.ready) begin
						out_valid_q  <= 1'b1;
						out_pos_q    <= pos_q;
						out_fwd_q    <= fwd_q;
						out_period_q <= period_q;
						out_speed_q  <= speed_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/epsm_checker.sv
// Port-level checks for the encoder period speed meter, bound to the core module.
module epsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_position_count,
	input logic [15:0] out_rpm_tenths
);

	// a stalled result keeps its valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// a stalled result keeps its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_position_count) && $stable(out_rpm_tenths))
		else $error("result changed while stalled");

	// an item in work blocks the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accept");

	// a tick item goes from the accept through the finish state into the result register when it is free
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_operation && !out_valid |-> ##2 out_valid)
		else $error("tick result late");

	// a tick never moves the position
	a_tick_keeps_position: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_operation && out_valid && out_ready
		|-> ##2 (out_position_count == $past(out_position_count, 2)))
		else $error("tick changed the position");

endmodule

bind encoder_period_speed_meter_core epsm_checker u_epsm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (item_in.valid),
	.in_ready           (item_in.ready),
	.in_operation       (item_in.operation),
	.out_valid          (result_out.valid),
	.out_ready          (result_out.ready),
	.out_position_count (result_out.position_count),
	.out_rpm_tenths     (result_out.rpm_tenths)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the encoder period speed meter core.
`timescale 1ns / 100ps

module tb_top;
	import epsm_pkg::*;

	// Run control: cycles of no handshake before giving up, and the long
	// receiver hold-off used to back the block up.
	localparam int IDLE_LIMIT  = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int ITEMS_PHASE = 140;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic        op;
		logic [31:0] stamp;
		logic        dir;
	} enc_event_t;

	typedef struct {
		logic [31:0] pos;
		logic        fwd;
		logic [31:0] period;
		logic [15:0] rpm;
	} meter_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	epsm_in_if  in_ch ();
	epsm_out_if out_ch ();

	encoder_period_speed_meter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_in    (in_ch),
		.result_out (out_ch)
	);

	// Shadow copy of the configuration registers, at their widths.
	logic [CLK_HZ_W-1:0] sh_clock_hz;
	logic [PPR_W-1:0]    sh_ppr;
	logic [TICK_W-1:0]   sh_tick_ms;
	logic [TMO_W-1:0]    sh_timeout_ms;

	// Shadow copy of the meter state.
	logic [TIME_W-1:0]  mt_prev_time;
	logic [TIME_W-1:0]  mt_period;
	logic [POS_W-1:0]   mt_position;
	logic               mt_forward;
	logic [SPEED_W-1:0] mt_speed;
	logic [QUIET_W-1:0] mt_quiet;

	enc_event_t event_q[$];     // items waiting to be offered
	meter_res_t meter_exp_q[$]; // predicted results, oldest first

	int          err_count;
	logic [31:0] gen_time;      // last capture time handed to the event queue

	// Driver state
	enc_event_t cur_event;
	int         burst_left;
	int         gap_left;

	// Monitor state
	int   rx_mode;
	int   rx_mode_left;
	int   rx_phase;
	int   hold_left;
	logic long_hold_req;
	logic long_hold_done;
	logic rdy_next;

	int   idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the shadow meter by one event and return the result it shows.
	function automatic meter_res_t meter_advance(enc_event_t ev);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quot;
		logic [16:0] quiet_sum;
		meter_res_t  r;
		if (ev.op == OP_PULSE) begin
			mt_period    = ev.stamp - mt_prev_time;
			mt_prev_time = ev.stamp;
			mt_forward   = ev.dir;
			mt_position  = ev.dir ? mt_position + 32'd1 : mt_position - 32'd1;
			mt_quiet     = '0;
			num = 64'(sh_clock_hz) * 64'd600;
			den = 64'(sh_ppr) * 64'(mt_period);
			// zero divisor (zero period or zero ppr): keep the old speed
			if (den != 64'd0) begin
				quot     = num / den;
				mt_speed = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
			end
		end else begin
			quiet_sum = {1'b0, mt_quiet} + 17'(sh_tick_ms);
			mt_quiet  = quiet_sum[16] ? 16'hFFFF : quiet_sum[15:0];
			// strict compare, checked on ticks only
			if (mt_quiet > sh_timeout_ms)
				mt_speed = '0;
		end
		r.pos    = mt_position;
		r.fwd    = mt_forward;
		r.period = mt_period;
		r.rpm    = mt_speed;
		return r;
	endfunction

	// Driver: offer queued items in bursts with random gaps; predict on accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				meter_exp_q.push_back(meter_advance(cur_event));
			// bus is free for a new item: either idle or just accepted
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (event_q.size() > 0) begin
					cur_event = event_q.pop_front();
					in_ch.operation      <= cur_event.op;
					in_ch.capture_time   <= cur_event.stamp;
					in_ch.direction_high <= cur_event.dir;
					in_ch.valid          <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						// a quarter of the bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, meter_res_t want);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display({"mismatch (%s): exp pos=%0d fwd=%0b per=%0d rpm=%0d,",
				" got pos=%0d fwd=%0b per=%0d rpm=%0d"},
				what, $signed(want.pos), want.fwd, want.period, want.rpm,
				out_ch.position_count, out_ch.moving_forward, out_ch.period_ticks,
				out_ch.rpm_tenths);
	endtask

	// Monitor: check each accepted result; stall on a changing pattern.
	always @(posedge clk or negedge arst_n) begin
		meter_res_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_mode        = 0;
			rx_mode_left   = 0;
			rx_phase       = 0;
			hold_left      = 0;
			long_hold_done = 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (meter_exp_q.size() == 0) begin
					want = '{default: '0};
					report_mismatch("no result expected", want);
				end else begin
					want = meter_exp_q.pop_front();
					if (out_ch.position_count !== want.pos ||
						out_ch.moving_forward !== want.fwd ||
						out_ch.period_ticks !== want.period ||
						out_ch.rpm_tenths !== want.rpm)
						report_mismatch("field", want);
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(20, 120);
			end else begin
				rx_mode_left--;
			end
			rx_phase++;
			if (hold_left > 0) begin
				hold_left--;
				rdy_next = 1'b0;
			end else if (long_hold_req && !long_hold_done) begin
				// back the block up: hold ready low while the sender keeps offering
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
				rdy_next       = 1'b0;
			end else begin
				case (rx_mode)
					0: rdy_next = 1'b1;
					1: rdy_next = ($urandom_range(0, 1) == 0);
					2: rdy_next = ((rx_phase % 4) == 0);
					default: rdy_next = ($urandom_range(0, 4) != 0);
				endcase
			end
			out_ch.ready <= rdy_next;
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic push_pulse(logic [31:0] stamp, logic dir);
		event_q.push_back('{OP_PULSE, stamp, dir});
		gen_time = stamp;
	endtask

	// Ticks carry random junk in the pulse-only fields.
	task automatic push_tick();
		event_q.push_back('{OP_TICK, 32'($urandom), 1'($urandom_range(0, 1))});
	endtask

	// Write one register and mirror it, masked to its width.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_CLOCK_HZ:   sh_clock_hz   = data[CLK_HZ_W-1:0];
			REG_PULSES_REV: sh_ppr        = data[PPR_W-1:0];
			REG_TICK_MS:    sh_tick_ms    = data[TICK_W-1:0];
			default:        sh_timeout_ms = data[TMO_W-1:0];
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [CFG_W-1:0] hz, logic [CFG_W-1:0] ppr,
		logic [CFG_W-1:0] tick, logic [CFG_W-1:0] tmo);
		write_reg(REG_CLOCK_HZ, hz);
		write_reg(REG_PULSES_REV, ppr);
		write_reg(REG_TICK_MS, tick);
		write_reg(REG_TIMEOUT_MS, tmo);
		end_writes();
	endtask

	// Hold until every queued item is accepted and every result has come back.
	// Sample at the falling edge so the clocked processes have settled.
	task automatic drain();
		while (event_q.size() != 0 || in_ch.valid || meter_exp_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random traffic: mostly pulses with periods around the interesting speed
	// range, plus runs of ticks, some long enough to reach the timeout.
	task automatic gen_random(int count);
		int          k;
		int          run;
		int          need;
		logic [63:0] base;
		logic [63:0] den;
		logic [31:0] delta;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 9) < 2) begin
				need = (sh_tick_ms == 0) ? 3 : int'(sh_timeout_ms) / int'(sh_tick_ms) + 2;
				if (need > 80)
					need = 80;
				run = $urandom_range(1, need);
				repeat (run) push_tick();
				k += run;
			end else begin
				den  = 64'(sh_ppr) * 64'd65535;
				base = (den == 64'd0) ? 64'd1 : (64'(sh_clock_hz) * 64'd600) / den + 64'd1;
				case ($urandom_range(0, 15))
					0:             delta = 32'd0;
					1:             delta = 32'($urandom) - gen_time;
					2, 3, 4:       delta = $urandom_range(1, 16);
					13, 14, 15:    delta = 32'($urandom) >> $urandom_range(0, 31);
					default:       delta = 32'(base * 64'($urandom_range(1, 64)));
				endcase
				push_pulse(gen_time + delta, 1'($urandom_range(0, 1)));
				k++;
			end
		end
	endtask

	// Register value with random junk above the register's width.
	function automatic logic [CFG_W-1:0] junk_above(int width, logic [CFG_W-1:0] val);
		logic [CFG_W-1:0] mask;
		mask = (CFG_W'(1) << width) - CFG_W'(1);
		return (val & mask) | (CFG_W'($urandom) & ~mask);
	endfunction

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_ch.valid          = 1'b0;
		in_ch.operation      = OP_PULSE;
		in_ch.capture_time   = '0;
		in_ch.direction_high = 1'b0;
		out_ch.ready         = 1'b0;
		long_hold_req = 1'b0;
		err_count     = 0;
		idle_cycles   = 0;
		gen_time      = '0;

		sh_clock_hz   = CLOCK_HZ_RST;
		sh_ppr        = PULSES_REV_RST;
		sh_tick_ms    = TICK_MS_RST;
		sh_timeout_ms = TIMEOUT_MS_RST;
		mt_prev_time  = '0;
		mt_period     = '0;
		mt_position   = '0;
		mt_forward    = 1'b1;
		mt_speed      = '0;
		mt_quiet      = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset configuration: first pulse against time zero,
		// saturation, zero period, wrapping timestamps, the 16-bit boundary.
		push_pulse(32'h0000_0000, 1'b1);
		push_pulse(32'h0000_0001, 1'b1);
		push_tick();
		push_pulse(32'h0000_0001, 1'b0);
		push_pulse(32'hFFFF_FFFF, 1'b0);
		push_pulse(32'h0000_3E7F, 1'b1);
		push_pulse(32'h0000_3E7F + 32'd1542, 1'b1);
		push_pulse(gen_time + 32'd1541, 1'b0);
		push_tick();
		push_tick();
		drain();

		// Timeout at the strict boundary: equal does not fire, above does.
		write_all(CLOCK_HZ_RST, CFG_W'(PULSES_REV_RST), 27'd1000, 27'd2000);
		push_pulse(gen_time + 32'd16000, 1'b1);
		push_tick();
		push_tick();
		push_tick();
		push_pulse(gen_time + 32'd16000, 1'b1);
		push_tick();
		drain();

		// Zero ppr keeps the speed; zero clock gives zero speed.
		write_all(CLOCK_HZ_RST, 27'd0, 27'd1000, 27'd2000);
		push_pulse(gen_time + 32'd100, 1'b0);
		push_pulse(gen_time + 32'd100, 1'b1);
		drain();
		write_all(27'd0, 27'd1, 27'd1000, 27'd2000);
		push_pulse(gen_time + 32'd1, 1'b1);
		drain();

		// Widest clock and ppr; timeout that never fires.
		write_all(27'h7FF_FFFF, 27'd4095, 27'd1000, 27'd65535);
		push_pulse(gen_time + 32'd1, 1'b0);
		push_pulse(gen_time + 32'd300, 1'b1);
		push_pulse(gen_time + 32'd301, 1'b1);
		push_tick();
		drain();

		// Random phases. Back the block up with a long receiver hold in the first.
		write_all(CLOCK_HZ_RST, CFG_W'(PULSES_REV_RST), CFG_W'(TICK_MS_RST),
			CFG_W'(TIMEOUT_MS_RST));
		long_hold_req = 1'b1;
		gen_random(ITEMS_PHASE);
		drain();

		// Pause the sender mid-phase until every result is back.
		write_all(27'd100000000, 27'd1, 27'd1, 27'd1);
		gen_random(ITEMS_PHASE / 2);
		drain();
		gen_random(ITEMS_PHASE / 2);
		drain();

		// Quiet timer saturation and the smallest clock.
		write_all(27'd1, 27'd4095, 27'd1000, 27'd65535);
		gen_random(ITEMS_PHASE);
		drain();

		write_all(27'd100000000, 27'd2048, 27'd1000, 27'd65535);
		gen_random(ITEMS_PHASE);
		drain();

		// Random settings with junk above each register's width.
		repeat (3) begin
			write_all(($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
					: CFG_W'($urandom_range(1, 100000000)),
				junk_above(PPR_W, CFG_W'($urandom)),
				junk_above(TICK_W, CFG_W'($urandom)),
				junk_above(TMO_W, CFG_W'($urandom_range(0, 5) == 0 ? $urandom
					: $urandom_range(1, 3000))));
			gen_random(ITEMS_PHASE);
			drain();
		end

		repeat (30) @(posedge clk);
		if (err_count == 0 && meter_exp_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/epsm_pkg.sv
design/epsm_if.sv
design/epsm_div.sv
design/encoder_period_speed_meter_core.sv
design/epsm_checker.sv
verif/tb_top.sv
